/* rtl/core/dd_pkg.sv */
// ----------------------------------------------------------------------------
// dd_pkg: shared types and constants for the date difference pipeline
// Calendar tables, reciprocal constants and the result status code.
// ----------------------------------------------------------------------------
package dd_pkg;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FIRST_BAD  = 2'd1,
    ST_SECOND_BAD = 2'd2,
    ST_ORDER      = 2'd3
  } dd_status_t;

  // Converted date: validity flag and absolute day number
  typedef struct packed {
    logic        ok;
    logic [22:0] num;
  } dd_daynum_t;

  localparam int PIPE_DEPTH = 8;

  localparam logic [8:0]  DAYS_YEAR   = 9'd365;
  localparam logic [4:0]  DAYS_MONTH  = 5'd30;
  localparam logic [4:0]  FEB_LEAP    = 5'd29;
  localparam logic [6:0]  CENTURY     = 7'd100;

  // floor(x/25) for x < 4096: (x * Q25_MUL) >> Q25_SHIFT
  localparam logic [12:0] Q25_MUL     = 13'd5243;
  localparam int          Q25_SHIFT   = 17;

  // floor(2^31/365): estimate is the quotient or one below it
  localparam logic [22:0] Q365_MUL    = 23'd5883516;
  localparam int          Q365_SHIFT  = 31;

  // floor(r/30) for r < 365: (r * Q30_MUL) >> Q30_SHIFT
  localparam logic [9:0]  Q30_MUL     = 10'd547;
  localparam int          Q30_SHIFT   = 14;

  localparam logic [3:0]  MONTH_JAN   = 4'd1;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  localparam logic [3:0]  MONTH_DEC   = 4'd12;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before month m
  function automatic logic [8:0] month_prefix(input logic [3:0] m);
    logic [8:0] pre;
    case (m)
      4'd1:    pre = 9'd0;
      4'd2:    pre = 9'd31;
      4'd3:    pre = 9'd59;
      4'd4:    pre = 9'd90;
      4'd5:    pre = 9'd120;
      4'd6:    pre = 9'd151;
      4'd7:    pre = 9'd181;
      4'd8:    pre = 9'd212;
      4'd9:    pre = 9'd243;
      4'd10:   pre = 9'd273;
      4'd11:   pre = 9'd304;
      4'd12:   pre = 9'd334;
      default: pre = 9'd0;
    endcase
    return pre;
  endfunction

endpackage

/* rtl/core/date_difference_days.sv */
// ----------------------------------------------------------------------------
// date_difference_days: Gregorian date difference in days
// Checks two dates, converts each to a day number and returns the difference
// with a rough years / months / days split.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive the six in_ date fields and pulse start; a word is taken at
//   every clock edge with start high and busy low. busy is never raised, so
//   one date pair can be given in every cycle.
//   Output: out_valid is high for exactly one cycle with the result word on
//   the out_ ports; the receiver must take it then.
//   Pipeline: three stages of date conversion, one compare, four of the
//   years / months / days split. Throughput: one word per cycle.
//   Reset: rst_n low at a clock edge clears every in-flight valid bit; the
//   data path registers are not reset, but no word emerges from before reset.
//   Stalls: the receiver has no way to hold results off; the pipeline never
//   stops.
//   Status not ok: every count on the out_ ports is zero.
// ----------------------------------------------------------------------------
module date_difference_days (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [4:0]         in_first_day,
  input  logic [3:0]         in_first_month,
  input  logic [13:0]        in_first_year,
  input  logic [4:0]         in_second_day,
  input  logic [3:0]         in_second_month,
  input  logic [13:0]        in_second_year,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [21:0]        out_total_days,
  output logic [13:0]        out_span_years,
  output logic [3:0]         out_span_months,
  output logic [4:0]         out_span_days
);
  import dd_pkg::*;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;

  dd_daynum_t  first_num;
  dd_daynum_t  second_num;
  dd_status_t  cmp_status;
  logic [22:0] cmp_diff;
  dd_status_t  sp_status;
  logic [22:0] sp_total;
  logic [14:0] sp_years;

  assign busy    = 1'b0;
  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  dd_conv u_conv_first (
    .clk   (clk),
    .day   (in_first_day),
    .month (in_first_month),
    .year  (in_first_year),
    .dnum  (first_num)
  );

  dd_conv u_conv_second (
    .clk   (clk),
    .day   (in_second_day),
    .month (in_second_month),
    .year  (in_second_year),
    .dnum  (second_num)
  );

  dd_cmp u_cmp (
    .clk    (clk),
    .first  (first_num),
    .second (second_num),
    .status (cmp_status),
    .diff   (cmp_diff)
  );

  dd_split u_split (
    .clk       (clk),
    .status_in (cmp_status),
    .total_in  (cmp_diff),
    .status    (sp_status),
    .total     (sp_total),
    .years     (sp_years),
    .months    (out_span_months),
    .days      (out_span_days)
  );

  assign out_valid      = vld_r[PIPE_DEPTH-1];
  assign out_status     = sp_status;
  assign out_total_days = sp_total[21:0];
  assign out_span_years = sp_years[13:0];

endmodule

/* rtl/core/dd_conv.sv */
// ----------------------------------------------------------------------------
// dd_conv: date check and day number conversion
// Three register stages: divide and table look-up, leap and validity check,
// final day number sum.
// ----------------------------------------------------------------------------
module dd_conv (
  input  logic              clk,
  input  logic [4:0]        day,
  input  logic [3:0]        month,
  input  logic [13:0]       year,
  output dd_pkg::dd_daynum_t dnum
);
  import dd_pkg::*;

  // stage 1
  logic [13:0] lc;
  logic [24:0] qy_p;
  logic [24:0] qlc_p;
  logic [22:0] y365;
  logic        ok_nxt;

  logic [13:0] year_r;
  logic [7:0]  qy_r;
  logic [7:0]  qlc_r;
  logic [11:0] lcq4_r;
  logic [22:0] y365_r;
  logic [8:0]  pre_r;
  logic [4:0]  day_r;
  logic [4:0]  mlen_r;
  logic        feb_r;
  logic        ok_r;

  // stage 2
  logic [13:0] c100;
  logic        rem0;
  logic        leap;
  logic [4:0]  lim;
  logic        vd2_nxt;
  logic [22:0] a_nxt;
  logic [11:0] b_nxt;

  logic        vd2_r;
  logic [22:0] a_r;
  logic [11:0] b_r;

  // stage 3
  dd_daynum_t  dnum_nxt;
  dd_daynum_t  dnum_r;

  assign lc     = (month <= MONTH_FEB && year != 14'd0) ? year - 14'd1 : year;
  assign qy_p   = {13'd0, year[13:2]} * {12'd0, Q25_MUL};
  assign qlc_p  = {13'd0, lc[13:2]} * {12'd0, Q25_MUL};
  assign y365   = {9'd0, year} * {14'd0, DAYS_YEAR};
  assign ok_nxt = (month >= MONTH_JAN) && (month <= MONTH_DEC) &&
                  (year != 14'd0) && (day != 5'd0);

  always_ff @(posedge clk) begin
    year_r <= year;
    qy_r   <= qy_p[Q25_SHIFT +: 8];
    qlc_r  <= qlc_p[Q25_SHIFT +: 8];
    lcq4_r <= lc[13:2];
    y365_r <= y365;
    pre_r  <= month_prefix(month);
    day_r  <= day;
    mlen_r <= month_len(month);
    feb_r  <= (month == MONTH_FEB);
    ok_r   <= ok_nxt;
  end

  assign c100    = {6'd0, qy_r} * {7'd0, CENTURY};
  assign rem0    = (year_r == c100);
  assign leap    = ((year_r[1:0] == 2'd0) && !rem0) || (rem0 && (qy_r[1:0] == 2'd0));
  assign lim     = (feb_r && leap) ? FEB_LEAP : mlen_r;
  assign vd2_nxt = ok_r && (day_r <= lim);
  assign a_nxt   = y365_r + {14'd0, pre_r} + {18'd0, day_r};
  assign b_nxt   = lcq4_r - {4'd0, qlc_r} + {6'd0, qlc_r[7:2]};

  always_ff @(posedge clk) begin
    vd2_r <= vd2_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  always_comb begin
    dnum_nxt.ok  = vd2_r;
    dnum_nxt.num = a_r + {11'd0, b_r};
  end

  always_ff @(posedge clk) begin
    dnum_r <= dnum_nxt;
  end

  assign dnum = dnum_r;

endmodule

/* rtl/core/dd_cmp.sv */
// ----------------------------------------------------------------------------
// dd_cmp: status decision and day number subtraction
// One register stage; the difference is zero unless both dates are valid
// and in order.
// ----------------------------------------------------------------------------
module dd_cmp (
  input  logic               clk,
  input  dd_pkg::dd_daynum_t first,
  input  dd_pkg::dd_daynum_t second,
  output dd_pkg::dd_status_t status,
  output logic [22:0]        diff
);
  import dd_pkg::*;

  dd_status_t  status_nxt;
  dd_status_t  status_r;
  logic [22:0] diff_nxt;
  logic [22:0] diff_r;

  always_comb begin
    if (!first.ok) begin
      status_nxt = ST_FIRST_BAD;
    end else if (!second.ok) begin
      status_nxt = ST_SECOND_BAD;
    end else if (first.num > second.num) begin
      status_nxt = ST_ORDER;
    end else begin
      status_nxt = ST_OK;
    end
    diff_nxt = (status_nxt == ST_OK) ? second.num - first.num : 23'd0;
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    diff_r   <= diff_nxt;
  end

  assign status = status_r;
  assign diff   = diff_r;

endmodule

/* rtl/core/dd_split.sv */
// ----------------------------------------------------------------------------
// dd_split: years / months / days split of a day count
// Four register stages: reciprocal estimate, remainder, correction with
// month quotient, day remainder.
// ----------------------------------------------------------------------------
module dd_split (
  input  logic               clk,
  input  dd_pkg::dd_status_t status_in,
  input  logic [22:0]        total_in,
  output dd_pkg::dd_status_t status,
  output logic [22:0]        total,
  output logic [14:0]        years,
  output logic [3:0]         months,
  output logic [4:0]         days
);
  import dd_pkg::*;

  // stage 5: quotient estimate
  logic [45:0] p365;
  dd_status_t  st5_r;
  logic [22:0] t5_r;
  logic [14:0] q5_r;

  // stage 6: remainder
  logic [22:0] r6_full;
  dd_status_t  st6_r;
  logic [22:0] t6_r;
  logic [14:0] q6_r;
  logic [9:0]  r6_r;

  // stage 7: correction and month quotient
  logic        ge;
  logic [8:0]  r7;
  logic [18:0] p30;
  dd_status_t  st7_r;
  logic [22:0] t7_r;
  logic [14:0] q7_r;
  logic [8:0]  r7_r;
  logic [3:0]  m7_r;

  // stage 8: day remainder
  logic [8:0]  d8_full;
  dd_status_t  st8_r;
  logic [22:0] t8_r;
  logic [14:0] q8_r;
  logic [3:0]  m8_r;
  logic [4:0]  d8_r;

  assign p365 = {23'd0, total_in} * {23'd0, Q365_MUL};

  always_ff @(posedge clk) begin
    st5_r <= status_in;
    t5_r  <= total_in;
    q5_r  <= p365[Q365_SHIFT +: 15];
  end

  assign r6_full = t5_r - ({8'd0, q5_r} * {14'd0, DAYS_YEAR});

  always_ff @(posedge clk) begin
    st6_r <= st5_r;
    t6_r  <= t5_r;
    q6_r  <= q5_r;
    r6_r  <= r6_full[9:0];
  end

  assign ge  = (r6_r >= {1'b0, DAYS_YEAR});
  assign r7  = ge ? 9'(r6_r - {1'b0, DAYS_YEAR}) : r6_r[8:0];
  assign p30 = {10'd0, r7} * {9'd0, Q30_MUL};

  always_ff @(posedge clk) begin
    st7_r <= st6_r;
    t7_r  <= t6_r;
    q7_r  <= q6_r + {14'd0, ge};
    r7_r  <= r7;
    m7_r  <= p30[Q30_SHIFT +: 4];
  end

  assign d8_full = r7_r - ({5'd0, m7_r} * {4'd0, DAYS_MONTH});

  always_ff @(posedge clk) begin
    st8_r <= st7_r;
    t8_r  <= t7_r;
    q8_r  <= q7_r;
    m8_r  <= m7_r;
    d8_r  <= d8_full[4:0];
  end

  assign status = st8_r;
  assign total  = t8_r;
  assign years  = q8_r;
  assign months = m8_r;
  assign days   = d8_r;

endmodule

/* rtl/core/dd_checker.sv */
// ----------------------------------------------------------------------------
// dd_checker: port-level checks for date_difference_days
// Latency, zeroed counts on error status, range of the split and busy never raised.
// ----------------------------------------------------------------------------
module dd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [21:0] out_total_days,
  input  logic [13:0] out_span_years,
  input  logic [3:0]  out_span_months,
  input  logic [4:0]  out_span_days
);
  import dd_pkg::*;

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && rst_n, PIPE_DEPTH))
    else $error("result word without a matching accepted word");

  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_total_days == 22'd0 && out_span_years == 14'd0 &&
       out_span_months == 4'd0 && out_span_days == 5'd0))
    else $error("non-zero counts with error status");

  a_split_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_span_months <= 4'd12 && out_span_days <= 5'd29))
    else $error("split out of range");

  a_never_busy : assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

endmodule

bind date_difference_days dd_checker u_dd_checker (.*);
